[hdl/prte_pkg.sv]
// ----------------------------------------------------------------------------
// prte_pkg
// Shared types and constants for the periodic task release engine.
// ----------------------------------------------------------------------------
package prte_pkg;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_NULL  = 3'd1,
    ST_RANGE = 3'd2,
    ST_FULL  = 3'd3,
    ST_FAIL  = 3'd4
  } status_t;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_RUN = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    status_t     pre_status;
    logic [31:0] period_ms;
    logic [31:0] time_ms;
    logic [7:0]  fail_mask;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_LOAD,
    S_CHECK,
    S_DIV,
    S_DISP,
    S_FINAL
  } state_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DIV_STEPS   = 32;
  localparam int unsigned MASK_BITS   = 8;

endpackage

[hdl/prte_front.sv]
// ----------------------------------------------------------------------------
// prte_front
// Register port and request intake: holds the maximum period and pre-checks
// add requests before they enter the queue.
// ----------------------------------------------------------------------------
module prte_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [0:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           func,
  input  logic           has_callback,
  input  logic [31:0]    period_ms,
  input  logic [31:0]    time_ms,
  input  logic [7:0]     fail_mask,
  input  logic           q_full,
  output logic           q_push,
  output prte_pkg::cmd_t q_data
);
  import prte_pkg::*;

  logic [31:0] max_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_period <= 32'hFFFF_FFFF;
    end else if (psel && penable && pwrite) begin
      max_period <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? max_period : max_period;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.op         = func ? OP_RUN : OP_ADD;
    q_data.period_ms  = period_ms;
    q_data.time_ms    = time_ms;
    q_data.fail_mask  = fail_mask;
    if (!has_callback) begin
      q_data.pre_status = ST_NULL;
    end else if (period_ms == 32'd0 || period_ms > max_period) begin
      q_data.pre_status = ST_RANGE;
    end else begin
      q_data.pre_status = ST_OK;
    end
  end

endmodule

[hdl/prte_fifo.sv]
// ----------------------------------------------------------------------------
// prte_fifo
// Short request queue between intake and execution.
// ----------------------------------------------------------------------------
module prte_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  prte_pkg::cmd_t   wdata,
  output logic             full,
  input  prte_pkg::q_ctl_t ctl_in,
  output logic             empty,
  output prte_pkg::cmd_t   rdata
);
  import prte_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign full   = (count == CW'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rdata  = mem[rd_ptr];
  assign do_pop = ctl_in.pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/prte_back.sv]
// ----------------------------------------------------------------------------
// prte_back
// Execution: task table, release walk with a bit-serial divider, statistics
// counters and the result register.
// ----------------------------------------------------------------------------
module prte_back #(
  parameter int unsigned TASK_CAPACITY = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  prte_pkg::cmd_t    q_data,
  output prte_pkg::q_ctl_t  q_ctl,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        task_index,
  output logic              dispatched,
  output logic [2:0]        status,
  output logic              last,
  output logic [31:0]       dispatch_total,
  output logic [31:0]       missed_total,
  output logic [31:0]       failure_total
);
  import prte_pkg::*;

  localparam int unsigned IDXW = (TASK_CAPACITY > 1) ? $clog2(TASK_CAPACITY) : 1;
  localparam int unsigned CNTW = $clog2(TASK_CAPACITY + 1);
  localparam int unsigned SW   = $clog2(DIV_STEPS);

  logic [31:0] period_mem [TASK_CAPACITY];
  logic [31:0] last_mem   [TASK_CAPACITY];

  state_t         state;
  state_t         state_next;
  cmd_t           cmd;
  logic [CNTW-1:0] idx;
  logic [CNTW-1:0] task_count;
  logic [31:0]    prd_q;
  logic [31:0]    lst_q;
  logic [31:0]    rem;
  logic [31:0]    dvd;
  logic [SW-1:0]  step;
  status_t        fin_status;
  logic [31:0]    disp_cnt;
  logic [31:0]    miss_cnt;
  logic [31:0]    fail_cnt;

  logic           ofree;
  logic           load;
  logic [2:0]     r_index;
  logic           r_disp;
  status_t        r_status;
  logic           r_last;
  logic [31:0]    disp_cnt_next;
  logic [31:0]    miss_cnt_next;
  logic [31:0]    fail_cnt_next;
  logic [31:0]    elapsed;
  logic [32:0]    rem_sh;
  logic           ge;
  logic [31:0]    idx32;
  logic           fails;
  logic           add_ok;
  status_t        add_status;
  logic [32:0]    miss_sum;
  logic [32:0]    disp_sum;
  logic [32:0]    fail_sum;

  assign ofree   = !out_valid || !out_stall;
  assign elapsed = cmd.time_ms - lst_q;
  assign rem_sh  = {rem, dvd[31]};
  assign ge      = (rem_sh >= {1'b0, prd_q});
  assign idx32   = {{(32 - CNTW){1'b0}}, idx};
  assign fails   = (idx32 < 32'(MASK_BITS)) && cmd.fail_mask[idx32[2:0]];
  assign add_ok  = (task_count < CNTW'(TASK_CAPACITY));
  assign miss_sum = {1'b0, miss_cnt} + {1'b0, dvd - 32'd1};
  assign disp_sum = {1'b0, disp_cnt} + 33'd1;
  assign fail_sum = {1'b0, fail_cnt} + 33'd1;

  always_comb begin
    if (cmd.pre_status != ST_OK) begin
      add_status = cmd.pre_status;
    end else if (!add_ok) begin
      add_status = ST_FULL;
    end else begin
      add_status = ST_OK;
    end
  end

  always_comb begin
    state_next    = state;
    q_ctl.pop     = 1'b0;
    q_ctl.empty   = q_empty;
    load          = 1'b0;
    r_index       = 3'd0;
    r_disp        = 1'b0;
    r_status      = ST_OK;
    r_last        = 1'b1;
    disp_cnt_next = disp_cnt;
    miss_cnt_next = miss_cnt;
    fail_cnt_next = fail_cnt;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_ctl.pop  = 1'b1;
          state_next = (q_data.op == OP_ADD) ? S_ADD : S_LOAD;
        end
      end
      S_ADD: begin
        if (ofree) begin
          load       = 1'b1;
          r_status   = add_status;
          state_next = S_IDLE;
        end
      end
      S_LOAD: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (idx >= task_count) begin
          state_next = S_FINAL;
        end else if (prd_q == 32'd0 || elapsed < prd_q) begin
          state_next = S_LOAD;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (step == SW'(DIV_STEPS - 1)) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (ofree) begin
          load          = 1'b1;
          r_index       = idx32[2:0];
          r_disp        = 1'b1;
          r_status      = fails ? ST_FAIL : ST_OK;
          r_last        = 1'b0;
          disp_cnt_next = disp_sum[32] ? 32'hFFFF_FFFF : disp_sum[31:0];
          if (dvd > 32'd1) begin
            miss_cnt_next = miss_sum[32] ? 32'hFFFF_FFFF : miss_sum[31:0];
          end
          if (fails) begin
            fail_cnt_next = fail_sum[32] ? 32'hFFFF_FFFF : fail_sum[31:0];
          end
          state_next = fails ? S_FINAL : S_LOAD;
        end
      end
      S_FINAL: begin
        if (ofree) begin
          load       = 1'b1;
          r_status   = fin_status;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prd_q <= period_mem[idx[IDXW-1:0]];
    lst_q <= last_mem[idx[IDXW-1:0]];
    if (state == S_ADD && ofree && add_status == ST_OK) begin
      period_mem[task_count[IDXW-1:0]] <= cmd.period_ms;
      last_mem[task_count[IDXW-1:0]]   <= cmd.time_ms;
    end
    if (state == S_DISP && ofree) begin
      last_mem[idx[IDXW-1:0]] <= cmd.time_ms - rem;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && !q_empty) begin
      cmd <= q_data;
    end
    case (state)
      S_CHECK: begin
        rem  <= 32'd0;
        dvd  <= elapsed;
        step <= '0;
      end
      S_DIV: begin
        rem  <= ge ? 32'(rem_sh - {1'b0, prd_q}) : rem_sh[31:0];
        dvd  <= {dvd[30:0], ge};
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
      idx        <= '0;
      fin_status <= ST_OK;
      disp_cnt   <= 32'd0;
      miss_cnt   <= 32'd0;
      fail_cnt   <= 32'd0;
      out_valid  <= 1'b0;
    end else begin
      disp_cnt <= disp_cnt_next;
      miss_cnt <= miss_cnt_next;
      fail_cnt <= fail_cnt_next;
      if (state == S_IDLE) begin
        idx        <= '0;
        fin_status <= ST_OK;
      end
      if (state == S_ADD && ofree && add_status == ST_OK) begin
        task_count <= task_count + 1'b1;
      end
      if (state == S_CHECK && state_next == S_LOAD) begin
        idx <= idx + 1'b1;
      end
      if (state == S_DISP && ofree) begin
        if (fails) begin
          fin_status <= ST_FAIL;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      task_index     <= r_index;
      dispatched     <= r_disp;
      status         <= r_status;
      last           <= r_last;
      dispatch_total <= disp_cnt_next;
      missed_total   <= miss_cnt_next;
      failure_total  <= fail_cnt_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    task_count <= CNTW'(TASK_CAPACITY))
    else $error("task count above capacity");

  a_disp_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> disp_cnt >= $past(disp_cnt))
    else $error("dispatch counter went backwards");

  a_status_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dispatched |-> task_index == 3'd0 && last)
    else $error("status result malformed");

  a_disp_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && dispatched |-> !last && (status == ST_OK || status == ST_FAIL))
    else $error("dispatch result malformed");
`endif

endmodule

[hdl/periodic_task_release_engine.sv]
// ----------------------------------------------------------------------------
// periodic_task_release_engine
// Periodic task table with add and run requests.
//
// Requests enter on in_valid/in_stall and wait in a two-deep queue; results
// leave on out_valid/out_stall from a single result register.
// An add request gives one status result: it leaves the queue into the add
// state, which loads the result register once the output is free. A run
// request walks the table in order, loading and checking each task; a due
// task goes through the bit-serial 32-step divider that counts whole
// elapsed periods and then gives a dispatch result. A failed dispatch ends
// the walk early; one closing status result follows.
// The queue keeps taking requests while a pass runs; in_stall rises only
// when it is full. A stalled result holds its value and the walk pauses
// until it is taken. The user writes max_period_ms over the register port
// only while the block is idle; the block itself does not enforce this.
// Reset clears the queue, the task count and the counters, and sets
// max_period_ms to all ones; the table itself needs no clearing.
// ----------------------------------------------------------------------------
module periodic_task_release_engine #(
  parameter int unsigned TASK_CAPACITY = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic        has_callback,
  input  logic [31:0] period_ms,
  input  logic [31:0] time_ms,
  input  logic [7:0]  fail_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  task_index,
  output logic        dispatched,
  output logic [2:0]  status,
  output logic        last,
  output logic [31:0] dispatch_total,
  output logic [31:0] missed_total,
  output logic [31:0] failure_total
);
  import prte_pkg::*;

  logic   q_full;
  logic   q_push;
  cmd_t   q_wdata;
  cmd_t   q_rdata;
  logic   q_empty;
  q_ctl_t q_ctl;

  prte_front u_front (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .has_callback (has_callback),
    .period_ms    (period_ms),
    .time_ms      (time_ms),
    .fail_mask    (fail_mask),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  prte_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .ctl_in (q_ctl),
    .empty  (q_empty),
    .rdata  (q_rdata)
  );

  prte_back #(
    .TASK_CAPACITY (TASK_CAPACITY)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_ctl          (q_ctl),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .task_index     (task_index),
    .dispatched     (dispatched),
    .status         (status),
    .last           (last),
    .dispatch_total (dispatch_total),
    .missed_total   (missed_total),
    .failure_total  (failure_total)
  );

endmodule
